// ----- src/rhsl_pkg.sv -----
`timescale 1ns / 1ps

package rhsl_pkg;

    // Default fraction width: 1 << FRAC_BITS stands for 1.0.
    localparam int FRAC_BITS_DEF = 12;

    // Fixed widths of the external fields.
    localparam int CHAN_W  = 16;
    localparam int HUE_W   = 12;
    localparam int SAT_W   = 13;
    localparam int LIGHT_W = 13;

    // Control that travels alongside the data through the chain.
    typedef struct packed {
        logic valid;
        logic grey;
    } t_ctl;

endpackage

// ----- src/rhsl_prep.sv -----
`timescale 1ns / 1ps

module rhsl_prep import rhsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CW = FRAC_BITS + 1,
    localparam int RW = 2 * FRAC_BITS + 3,
    localparam int DW = FRAC_BITS + 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [CHAN_W-1:0] i_red,
    input  logic signed [CHAN_W-1:0] i_green,
    input  logic signed [CHAN_W-1:0] i_blue,
    output t_ctl                     o_ctl,
    output logic [CW-1:0]            o_light,
    output logic [RW-1:0]            o_sat_rem,
    output logic [DW-1:0]            o_sat_div,
    output logic [RW-1:0]            o_hue_rem,
    output logic [DW-1:0]            o_hue_div
);

    localparam int SW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 4;
    localparam logic [31:0] ONE_32 = 32'(1) << FRAC_BITS;
    localparam logic [SW-1:0] ONE_S = SW'(ONE_32);
    localparam logic [SW-1:0] TWO_S = SW'(ONE_32 << 1);

    function automatic logic [CW-1:0] clamp(input logic signed [CHAN_W-1:0] v);
        logic [31:0] u;
        u = 32'(unsigned'(v));
        if (v < 0) begin
            return '0;
        end else if (u > ONE_32) begin
            return CW'(ONE_32);
        end else begin
            return CW'(u);
        end
    endfunction

    // Stage A: clamp.
    logic          r_a_valid;
    logic [CW-1:0] r_r, r_g, r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_r <= clamp(i_red);
        r_g <= clamp(i_green);
        r_b <= clamp(i_blue);
    end

    // Stage B: extremes, lightness, divisors and dividends.
    logic [CW-1:0] mx, mn, d;
    logic [SW-1:0] sum;
    logic [NW-1:0] nd, six_d, num;
    logic [DW-1:0] n_sat_div;

    always_comb begin
        mx = r_r;
        mn = r_r;
        if (r_g > mx) mx = r_g;
        if (r_b > mx) mx = r_b;
        if (r_g < mn) mn = r_g;
        if (r_b < mn) mn = r_b;
        sum   = SW'(mx) + SW'(mn);
        d     = mx - mn;
        nd    = NW'(d);
        six_d = (nd << 2) + (nd << 1);
        // Ties go to red, then green. Intermediate wrap cancels out.
        if (mx == r_r) begin
            num = (r_g < r_b) ? (six_d + NW'(r_g) - NW'(r_b)) : (NW'(r_g) - NW'(r_b));
        end else if (mx == r_g) begin
            num = (nd << 1) + NW'(r_b) - NW'(r_r);
        end else begin
            num = (nd << 2) + NW'(r_r) - NW'(r_g);
        end
        n_sat_div = (sum > ONE_S) ? DW'(TWO_S - sum) : DW'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else begin
            o_ctl.valid <= r_a_valid;
        end
        o_ctl.grey <= (d == '0);
        o_light    <= CW'(sum >> 1);
        o_sat_rem  <= RW'(d) << FRAC_BITS;
        o_sat_div  <= n_sat_div;
        o_hue_rem  <= RW'(num) << FRAC_BITS;
        o_hue_div  <= DW'(six_d);
    end

endmodule

// ----- src/rhsl_div_cell.sv -----
`timescale 1ns / 1ps

module rhsl_div_cell import rhsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SHIFT = 0,
    localparam int CW = FRAC_BITS + 1,
    localparam int RW = 2 * FRAC_BITS + 3,
    localparam int DW = FRAC_BITS + 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [CW-1:0] i_light,
    input  logic [RW-1:0] i_sat_rem,
    input  logic [DW-1:0] i_sat_div,
    input  logic [CW-1:0] i_sat_q,
    input  logic [RW-1:0] i_hue_rem,
    input  logic [DW-1:0] i_hue_div,
    input  logic [CW-1:0] i_hue_q,
    output t_ctl          o_ctl,
    output logic [CW-1:0] o_light,
    output logic [RW-1:0] o_sat_rem,
    output logic [DW-1:0] o_sat_div,
    output logic [CW-1:0] o_sat_q,
    output logic [RW-1:0] o_hue_rem,
    output logic [DW-1:0] o_hue_div,
    output logic [CW-1:0] o_hue_q
);

    // One restoring step per quotient; quotient bits enter from the right.
    logic [RW-1:0] sat_sh, hue_sh;
    logic          sat_bit, hue_bit;

    always_comb begin
        sat_sh  = RW'(i_sat_div) << SHIFT;
        hue_sh  = RW'(i_hue_div) << SHIFT;
        sat_bit = (i_sat_rem >= sat_sh);
        hue_bit = (i_hue_rem >= hue_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else begin
            o_ctl.valid <= i_ctl.valid;
        end
        o_ctl.grey <= i_ctl.grey;
        o_light    <= i_light;
        o_sat_rem  <= sat_bit ? (i_sat_rem - sat_sh) : i_sat_rem;
        o_hue_rem  <= hue_bit ? (i_hue_rem - hue_sh) : i_hue_rem;
        o_sat_div  <= i_sat_div;
        o_hue_div  <= i_hue_div;
        o_sat_q    <= {i_sat_q[CW-2:0], sat_bit};
        o_hue_q    <= {i_hue_q[CW-2:0], hue_bit};
    end

endmodule

// ----- src/rgb_to_hsl_converter.sv -----
// An item taken is registered by the clamp stage, then the front-end stage, then each divider
// cell in turn; o_valid and the results are driven straight from the last cell.
// Throughput: one item per clock; busy is never raised, and a new item may start every cycle.
// The rate is set by the chain of divider cells, each holding one item and settling one bit of both quotients.
// Results appear on o_valid for exactly one cycle; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) drops every item in flight; no result follows it.
`timescale 1ns / 1ps

module rgb_to_hsl_converter import rhsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CHAN_W-1:0] i_red,
    input  logic signed [CHAN_W-1:0] i_green,
    input  logic signed [CHAN_W-1:0] i_blue,
    output logic                     o_valid,
    output logic [HUE_W-1:0]         o_hue,
    output logic [SAT_W-1:0]         o_saturation,
    output logic [LIGHT_W-1:0]       o_lightness
);

    localparam int CW = FRAC_BITS + 1;
    localparam int RW = 2 * FRAC_BITS + 3;
    localparam int DW = FRAC_BITS + 3;
    // One cell per quotient bit, most significant first.
    localparam int NCELL = FRAC_BITS + 1;
    localparam logic [31:0] ONE_32 = 32'(1) << FRAC_BITS;

    // The block is fully pipelined, so it never refuses an item.
    assign busy = 1'b0;

    // Chain links: index 0 is the output of the front end, index NCELL that of the last cell.
    t_ctl          c_ctl     [NCELL+1];
    logic [CW-1:0] c_light   [NCELL+1];
    logic [RW-1:0] c_sat_rem [NCELL+1];
    logic [DW-1:0] c_sat_div [NCELL+1];
    logic [CW-1:0] c_sat_q   [NCELL+1];
    logic [RW-1:0] c_hue_rem [NCELL+1];
    logic [DW-1:0] c_hue_div [NCELL+1];
    logic [CW-1:0] c_hue_q   [NCELL+1];

    // The front end clamps the channels, then forms lightness, the two divisors
    // and the two dividends (each dividend already scaled by 1.0).
    rhsl_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_ctl     (c_ctl[0]),
        .o_light   (c_light[0]),
        .o_sat_rem (c_sat_rem[0]),
        .o_sat_div (c_sat_div[0]),
        .o_hue_rem (c_hue_rem[0]),
        .o_hue_div (c_hue_div[0])
    );

    assign c_sat_q[0] = '0;
    assign c_hue_q[0] = '0;

    // Each cell settles one bit of both quotients and hands the item on.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rhsl_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .SHIFT     (FRAC_BITS - k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (c_ctl[k]),
            .i_light   (c_light[k]),
            .i_sat_rem (c_sat_rem[k]),
            .i_sat_div (c_sat_div[k]),
            .i_sat_q   (c_sat_q[k]),
            .i_hue_rem (c_hue_rem[k]),
            .i_hue_div (c_hue_div[k]),
            .i_hue_q   (c_hue_q[k]),
            .o_ctl     (c_ctl[k+1]),
            .o_light   (c_light[k+1]),
            .o_sat_rem (c_sat_rem[k+1]),
            .o_sat_div (c_sat_div[k+1]),
            .o_sat_q   (c_sat_q[k+1]),
            .o_hue_rem (c_hue_rem[k+1]),
            .o_hue_div (c_hue_div[k+1]),
            .o_hue_q   (c_hue_q[k+1])
        );
    end

    // A grey pixel divides by zero in the chain; its hue and saturation are forced to zero.
    logic [31:0] hue_x, sat_x, light_x;

    always_comb begin
        hue_x   = c_ctl[NCELL].grey ? 32'd0 : 32'(c_hue_q[NCELL]);
        sat_x   = c_ctl[NCELL].grey ? 32'd0 : 32'(c_sat_q[NCELL]);
        light_x = 32'(c_light[NCELL]);
    end

    assign o_valid      = c_ctl[NCELL].valid;
    assign o_hue        = hue_x[HUE_W-1:0];
    assign o_saturation = sat_x[SAT_W-1:0];
    assign o_lightness  = light_x[LIGHT_W-1:0];

    // Saturation never exceeds 1.0.
    a_sat_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[NCELL].valid |-> 32'(c_sat_q[NCELL]) <= ONE_32 || c_ctl[NCELL].grey)
        else $error("saturation quotient above 1.0");

    // Hue stays below one full turn.
    a_hue_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[NCELL].valid |-> 32'(c_hue_q[NCELL]) < ONE_32 || c_ctl[NCELL].grey)
        else $error("hue quotient reached a full turn");

    // A colored pixel always has nonzero saturation; zero saturation implies zero hue.
    a_sat_hue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[NCELL].valid && c_sat_q[NCELL] == '0 |-> c_hue_q[NCELL] == '0 || c_ctl[NCELL].grey)
        else $error("zero saturation with nonzero hue");

    // Lightness never exceeds 1.0.
    a_light_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[NCELL].valid |-> 32'(c_light[NCELL]) <= ONE_32)
        else $error("lightness above 1.0");

endmodule

// ----- dv/tb_rgb_to_hsl_converter.sv -----
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;
    import rhsl_pkg::*;

    localparam int ONE = 1 << FRAC_BITS_DEF;
    localparam int LATENCY = FRAC_BITS_DEF + 3;
    localparam int N_RANDOM = 1350;
    localparam int CYCLE_LIMIT = 200000;

    // One color conversion result.
    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   sat;
        logic [LIGHT_W-1:0] light;
    } t_hsl;

    // Row of the directed table. When has_exp is set the expected result is
    // also typed in, and it is checked against the predictor as a sanity step.
    typedef struct {
        logic signed [CHAN_W-1:0] r, g, b;
        bit   has_exp;
        t_hsl exp_hsl;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [CHAN_W-1:0] i_red, i_green, i_blue;
    logic                     o_valid;
    logic [HUE_W-1:0]         o_hue;
    logic [SAT_W-1:0]         o_saturation;
    logic [LIGHT_W-1:0]       o_lightness;

    rgb_to_hsl_converter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_valid(o_valid), .o_hue(o_hue), .o_saturation(o_saturation),
        .o_lightness(o_lightness)
    );

    t_hsl pending_hsl[$];
    int   n_errors = 0;
    int   n_items = 0;
    int   n_results = 0;
    int   n_grey = 0;
    int   idle_pct = 0;
    longint cycle_count = 0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Clamp one signed channel to 0..ONE.
    function automatic int unsigned clamp_chan(logic signed [CHAN_W-1:0] v);
        if (v < 0) return 0;
        if (v > ONE) return ONE;
        return 32'(unsigned'(v));
    endfunction

    // Fixed-point HSL of one pixel; every quotient truncates.
    function automatic t_hsl hsl_of(logic signed [CHAN_W-1:0] rr,
                                    logic signed [CHAN_W-1:0] gg,
                                    logic signed [CHAN_W-1:0] bb);
        int unsigned r, g, b, top, bot, total, span, numer, h, s;
        t_hsl res;
        r = clamp_chan(rr);
        g = clamp_chan(gg);
        b = clamp_chan(bb);
        top = r;
        bot = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < bot) bot = g;
        if (b < bot) bot = b;
        total = top + bot;
        span = top - bot;
        h = 0;
        s = 0;
        if (span != 0) begin
            s = (total > ONE) ? (span * ONE) / (2 * ONE - total) : (span * ONE) / total;
            // Ties for the largest channel go to red, then green, then blue.
            if (top == r) numer = (g < b) ? 6 * span - (b - g) : g - b;
            else if (top == g) numer = 2 * span + b - r;
            else numer = 4 * span + r - g;
            h = (numer * ONE) / (6 * span);
        end
        res.hue = h[HUE_W-1:0];
        res.sat = s[SAT_W-1:0];
        res.light = total[LIGHT_W:1];
        return res;
    endfunction

    // Directed rows: extremes, clamping, grey, the tie-break order, each sextant.
    t_row directed[] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1, '{12'd0, 13'd0,    13'd0}},
        '{16'sd4096,   16'sd4096,   16'sd4096,   1, '{12'd0, 13'd0,    13'd4096}},
        '{-16'sd32768, -16'sd1,     -16'sd100,   1, '{12'd0, 13'd0,    13'd0}},
        '{16'sd32767,  16'sd5000,   16'sd4097,   1, '{12'd0, 13'd0,    13'd4096}},
        '{16'sd2048,   16'sd2048,   16'sd2048,   1, '{12'd0, 13'd0,    13'd2048}},
        '{16'sd4096,   16'sd0,      16'sd0,      1, '{12'd0, 13'd4096, 13'd2048}},
        '{16'sd32767,  -16'sd32768, -16'sd32768, 1, '{12'd0, 13'd4096, 13'd2048}},
        '{16'sd0,      16'sd4096,   16'sd0,      0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd0,      16'sd0,      16'sd4096,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd4096,   16'sd4096,   16'sd0,      0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd0,      16'sd4096,   16'sd4096,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd4096,   16'sd0,      16'sd4096,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd3000,   16'sd3000,   16'sd3000,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd3000,   16'sd1000,   16'sd2000,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd1000,   16'sd3000,   16'sd2000,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd2000,   16'sd1000,   16'sd3000,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd1,      16'sd0,      16'sd0,      0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd4096,   16'sd4095,   16'sd4096,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd4095,   16'sd4096,   16'sd4096,   0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd1,      16'sd2,      16'sd3,      0, '{12'd0, 13'd0,    13'd0}},
        '{16'sd3000,   16'sd4000,   16'sd3500,   0, '{12'd0, 13'd0,    13'd0}},
        '{-16'sd21846, 16'sd21845,  16'sd100,    0, '{12'd0, 13'd0,    13'd0}}
    };

    // Present one item and hold it until accepted. A random gap of idle
    // cycles precedes it, drawn from the current idle percentage.
    task automatic send_pixel(logic signed [CHAN_W-1:0] r, logic signed [CHAN_W-1:0] g,
                              logic signed [CHAN_W-1:0] b);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_hsl.push_back(hsl_of(r, g, b));
        if (clamp_chan(r) == clamp_chan(g) && clamp_chan(g) == clamp_chan(b))
            n_grey++;
        n_items++;
    endtask

    // Random channel: mostly in range, some near either end, some raw.
    function automatic logic signed [CHAN_W-1:0] rand_chan();
        int unsigned pick;
        pick = $urandom_range(9, 0);
        if (pick < 6) return CHAN_W'($urandom_range(ONE, 0));
        if (pick == 6) return CHAN_W'($urandom_range(ONE, ONE - 8));
        if (pick == 7) return CHAN_W'($urandom_range(8, 0));
        return CHAN_W'($urandom());
    endfunction

    // Results cannot be held off, so each strobe is checked on the edge
    // that accepts it.
    always @(posedge i_clk) begin
        t_hsl want;
        if (i_rst_n && o_valid) begin
            if (pending_hsl.size() == 0) begin
                $display("%0t: result with none expected: hue %0d sat %0d light %0d",
                         $time, o_hue, o_saturation, o_lightness);
                n_errors++;
            end else begin
                want = pending_hsl.pop_front();
                n_results++;
                if (o_hue !== want.hue) begin
                    $display("%0t: hue expected %0d actual %0d", $time, want.hue, o_hue);
                    n_errors++;
                end
                if (o_saturation !== want.sat) begin
                    $display("%0t: saturation expected %0d actual %0d",
                             $time, want.sat, o_saturation);
                    n_errors++;
                end
                if (o_lightness !== want.light) begin
                    $display("%0t: lightness expected %0d actual %0d",
                             $time, want.light, o_lightness);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_hsl.size());
            $display("rgb_to_hsl_converter verification failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int waited;
        t_hsl got;
        logic signed [CHAN_W-1:0] grey_lvl;
        start   = 1'b0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back.
        foreach (directed[k]) begin
            if (directed[k].has_exp) begin
                got = hsl_of(directed[k].r, directed[k].g, directed[k].b);
                if (got !== directed[k].exp_hsl) begin
                    $display("%0t: table row %0d expected %p actual %p",
                             $time, k, directed[k].exp_hsl, got);
                    n_errors++;
                end
            end
            send_pixel(directed[k].r, directed[k].g, directed[k].b);
        end

        // The sender pauses here until every expected result has come.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_hsl.size() != 0) @(posedge i_clk);

        // Random items in phases of sender idling; the receiver has no stall.
        for (int n = 0; n < N_RANDOM; n++) begin
            phase = (n * 4) / N_RANDOM;
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 73;
                2: idle_pct = 30;
                default: idle_pct = (n % 200 < 100) ? 0 : 73;
            endcase
            if ($urandom_range(15, 0) == 0) begin
                grey_lvl = CHAN_W'($urandom_range(ONE, 0));
                send_pixel(grey_lvl, grey_lvl, grey_lvl);
            end else begin
                send_pixel(rand_chan(), rand_chan(), rand_chan());
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        waited = 0;
        while (pending_hsl.size() != 0 && waited < 100 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (pending_hsl.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_hsl.size());
            n_errors += pending_hsl.size();
        end

        $display("Sent %0d pixels (%0d grey), checked %0d results, %0d mismatches.",
                 n_items, n_grey, n_results, n_errors);
        $display("Covered clamping, all sextants, ties and sender gaps of 0, 30 and 73 percent.");
        if (n_errors == 0)
            $display("rgb_to_hsl_converter verification clean");
        else
            $display("rgb_to_hsl_converter verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rhsl_pkg.sv
src/rhsl_prep.sv
src/rhsl_div_cell.sv
src/rgb_to_hsl_converter.sv
dv/tb_rgb_to_hsl_converter.sv
